FILE: hw/rtl/plss_pkg.sv
// Shared types and constants for the pulsed LED sensor sampler.
package plss_pkg;

	// Item selector codes carried in tuser
	localparam logic [1:0] FUNC_TICK   = 2'd0;
	localparam logic [1:0] FUNC_SAMPLE = 2'd1;
	localparam logic [1:0] FUNC_TRIG   = 2'd2;

	// Pulse phases
	localparam logic [1:0] PH_OFF    = 2'd0;
	localparam logic [1:0] PH_BEFORE = 2'd1;
	localparam logic [1:0] PH_AFTER  = 2'd2;

	localparam int SAMPLE_MAX  = 1023;
	localparam int MV_PER_LSB  = 5;
	localparam int MEAN_W      = 13;
	localparam int OUT_DEPTH   = 8;

	// Width of the running sum for n samples
	function automatic int sum_width(input int n);
		return $clog2(SAMPLE_MAX * n + 1);
	endfunction

	// Width of sum * 5, the dividend of the mean
	function automatic int dividend_width(input int n);
		return $clog2(SAMPLE_MAX * MV_PER_LSB * n + 1);
	endfunction

	// Per-item flags passed down the pipe
	typedef struct packed {
		logic running;
		logic mean_valid;
		logic start_conversion;
		logic led_on;
	} ctl_t;

	// One result item, led_on in bit 0
	typedef struct packed {
		logic              running;
		logic [MEAN_W-1:0] mean_mv;
		logic              mean_valid;
		logic              start_conversion;
		logic              led_on;
	} out_item_t;

endpackage

FILE: hw/rtl/plss_core.sv
// Pulse sequencer and sample accumulator, one item per cycle.
module plss_core import plss_pkg::*; #(
	parameter int SAMPLES_PER_MEAN = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid_s1,
	input  logic [1:0]                                    func_s1,
	input  logic [9:0]                                    sample_s1,
	input  logic [15:0]                                   off_ticks,
	input  logic [15:0]                                   before_sample_ticks,
	input  logic [15:0]                                   after_sample_ticks,
	input  logic                                          continuous_mode,
	output logic                                          res_valid_s2,
	output ctl_t                                          res_s2,
	output logic [dividend_width(SAMPLES_PER_MEAN)-1:0]   dividend_s2
);

	localparam int SUM_W = sum_width(SAMPLES_PER_MEAN);
	localparam int DIV_W = dividend_width(SAMPLES_PER_MEAN);
	localparam int CNT_W = $clog2(SAMPLES_PER_MEAN + 1);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_MEAN - 1);

	logic [1:0]       phase_q, phase_n;
	logic [15:0]      ticks_q, ticks_n;
	logic             led_q, led_n;
	logic             active_q, active_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [SUM_W-1:0] sum_q, sum_n, sum_add;
	logic [DIV_W-1:0] dividend;
	logic             conv, fresh;

	assign sum_add  = sum_q + SUM_W'(sample_s1);
	// sum * 5 as shift and add
	assign dividend = (DIV_W'(sum_add) << 2) + DIV_W'(sum_add);

	always_comb begin
		phase_n  = phase_q;
		ticks_n  = ticks_q;
		led_n    = led_q;
		active_n = active_q;
		cnt_n    = cnt_q;
		sum_n    = sum_q;
		conv     = 1'b0;
		fresh    = 1'b0;
		unique case (func_s1)
			FUNC_TICK: begin
				if (active_q) begin
					if (ticks_q > 16'd1) begin
						ticks_n = ticks_q - 16'd1;
					end else begin
						unique case (phase_q)
							PH_BEFORE: begin
								conv    = 1'b1;
								phase_n = PH_AFTER;
								ticks_n = after_sample_ticks;
							end
							PH_AFTER: begin
								led_n   = 1'b0;
								phase_n = PH_OFF;
								ticks_n = off_ticks;
							end
							default: begin
								led_n   = 1'b1;
								phase_n = PH_BEFORE;
								ticks_n = before_sample_ticks;
							end
						endcase
					end
				end
			end
			FUNC_SAMPLE: begin
				if (active_q) begin
					sum_n = sum_add;
					cnt_n = cnt_q + CNT_W'(1);
					if (cnt_q == LAST_CNT) begin
						// mean done: stop, LED off, restart in continuous mode
						fresh    = 1'b1;
						sum_n    = '0;
						cnt_n    = '0;
						led_n    = 1'b0;
						phase_n  = PH_OFF;
						active_n = continuous_mode;
						ticks_n  = continuous_mode ? off_ticks : 16'd0;
					end
				end
			end
			FUNC_TRIG: begin
				if (!active_q) begin
					active_n = 1'b1;
					led_n    = 1'b0;
					phase_n  = PH_OFF;
					ticks_n  = off_ticks;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_OFF;
			ticks_q      <= '0;
			led_q        <= 1'b0;
			active_q     <= 1'b0;
			cnt_q        <= '0;
			sum_q        <= '0;
			res_valid_s2 <= 1'b0;
		end else begin
			res_valid_s2 <= in_valid_s1;
			if (in_valid_s1) begin
				phase_q  <= phase_n;
				ticks_q  <= ticks_n;
				led_q    <= led_n;
				active_q <= active_n;
				cnt_q    <= cnt_n;
				sum_q    <= sum_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid_s1) begin
			res_s2.running          <= active_n;
			res_s2.mean_valid       <= fresh;
			res_s2.start_conversion <= conv;
			res_s2.led_on           <= led_n;
			dividend_s2             <= dividend;
		end
	end

endmodule

FILE: hw/rtl/plss_mean.sv
// Mean by reciprocal multiply and the held mean register.
module plss_mean import plss_pkg::*; #(
	parameter int SAMPLES_PER_MEAN = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        res_valid_s2,
	input  ctl_t                                        res_s2,
	input  logic [dividend_width(SAMPLES_PER_MEAN)-1:0] dividend_s2,
	output logic                                        item_valid,
	output out_item_t                                   item
);

	localparam int DIV_W = dividend_width(SAMPLES_PER_MEAN);
	localparam int SH    = DIV_W + $clog2(SAMPLES_PER_MEAN);
	// ceil(2^SH / N): exact floor quotient for any dividend below 2^DIV_W
	localparam longint MULT_L = ((64'sd1 <<< SH) + SAMPLES_PER_MEAN - 1) / SAMPLES_PER_MEAN;
	localparam int M_W    = $clog2(MULT_L + 1);
	localparam int PROD_W = DIV_W + M_W;
	localparam logic [M_W-1:0] MULT = M_W'(MULT_L);

	logic              valid_s3;
	ctl_t              res_s3;
	logic [PROD_W-1:0] prod_s3;
	logic [MEAN_W-1:0] held_q;
	logic [MEAN_W-1:0] quot;

	assign quot = MEAN_W'(prod_s3 >> SH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			held_q   <= '0;
		end else begin
			valid_s3 <= res_valid_s2;
			if (valid_s3 && res_s3.mean_valid) begin
				held_q <= quot;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid_s2) begin
			res_s3  <= res_s2;
			prod_s3 <= PROD_W'(dividend_s2) * PROD_W'(MULT);
		end
	end

	assign item_valid            = valid_s3;
	assign item.running          = res_s3.running;
	assign item.mean_valid       = res_s3.mean_valid;
	assign item.start_conversion = res_s3.start_conversion;
	assign item.led_on           = res_s3.led_on;
	assign item.mean_mv          = res_s3.mean_valid ? quot : held_q;

endmodule

FILE: hw/rtl/plss_fifo.sv
// Small register queue holding finished results for the output side.
module plss_fifo #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data   = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);

endmodule

FILE: hw/rtl/pulsed_led_sensor_sampler_unit.sv
// Top level of the pulsed LED sensor sampler: stream ports, APB registers, pipeline.
//
//  channel   | dir | payload                                  | transfer when
//  ----------+-----+------------------------------------------+------------------------------
//  s_axis    | in  | tuser: func, tdata: sample_value          | s_axis_tvalid & s_axis_tready
//  m_axis    | out | tdata: led_on..running (one result/item)  | m_axis_tvalid & m_axis_tready
//  apb       | in  | four config registers at 0x0,0x4,0x8,0xC  | psel & penable & pwrite
//
// One item per clock sustained while the result queue has credit. A result passes the
// input register, the sequencer/accumulator stage, the reciprocal multiply stage and the
// output queue write before it shows on m_axis. The rate is set by the sequencer state
// update.
// Reset (arst_n low) idles the sequencer, clears sum, count and held mean, and
// restores the register defaults.
// Input and output are decoupled by an 8-entry result queue; s_axis_tready is a
// registered credit check, so a stalled consumer stops input only once eight
// transfers are outstanding.
module pulsed_led_sensor_sampler_unit import plss_pkg::*; #(
	parameter int SAMPLES_PER_MEAN = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [9:0] sample_value, [15:10] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] func
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [0] led_on, [1] start_conversion, [2] mean_valid,
	                                    // [15:3] mean_mv, [16] running, [23:17] zero
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int DIV_W  = dividend_width(SAMPLES_PER_MEAN);
	localparam int PEND_W = $clog2(OUT_DEPTH + 1);
	localparam int ITEM_W = $bits(out_item_t);

	// register index codes (paddr[3:2])
	localparam logic [1:0] REG_OFF    = 2'd0;
	localparam logic [1:0] REG_BEFORE = 2'd1;
	localparam logic [1:0] REG_AFTER  = 2'd2;
	localparam logic [1:0] REG_CONT   = 2'd3;

	// config registers
	logic [15:0] off_ticks_q;
	logic [15:0] before_ticks_q;
	logic [15:0] after_ticks_q;
	logic        cont_q;
	logic        cfg_wr;
	logic [1:0]  cfg_idx;

	// pipeline
	logic             in_xfer, out_xfer;
	logic             valid_s1;
	logic [1:0]       func_s1;
	logic [9:0]       sample_s1;
	logic             res_valid_s2;
	ctl_t             res_s2;
	logic [DIV_W-1:0] dividend_s2;
	logic             item_valid;
	out_item_t        item;
	logic [ITEM_W-1:0] fifo_out;
	logic [PEND_W-1:0] pend_q;

	// ---------------- APB register file ----------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_ticks_q    <= 16'd9600;
			before_ticks_q <= 16'd280;
			after_ticks_q  <= 16'd40;
			cont_q         <= 1'b1;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_OFF:    off_ticks_q    <= pwdata[15:0];
				REG_BEFORE: before_ticks_q <= pwdata[15:0];
				REG_AFTER:  after_ticks_q  <= pwdata[15:0];
				REG_CONT:   cont_q         <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_OFF:    prdata = {16'd0, off_ticks_q};
			REG_BEFORE: prdata = {16'd0, before_ticks_q};
			REG_AFTER:  prdata = {16'd0, after_ticks_q};
			REG_CONT:   prdata = {31'd0, cont_q};
		endcase
	end

	// ---------------- flow control ----------------
	// pend_q counts items accepted but not yet sent; queue can always hold them all
	assign s_axis_tready = (pend_q < PEND_W'(OUT_DEPTH));
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_xfer      = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_xfer;
			if (in_xfer && !out_xfer) begin
				pend_q <= pend_q + PEND_W'(1);
			end else if (out_xfer && !in_xfer) begin
				pend_q <= pend_q - PEND_W'(1);
			end
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_s1   <= s_axis_tuser;
			sample_s1 <= s_axis_tdata[9:0];
		end
	end

	// ---------------- datapath ----------------
	plss_core #(
		.SAMPLES_PER_MEAN (SAMPLES_PER_MEAN)
	) u_core (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid_s1         (valid_s1),
		.func_s1             (func_s1),
		.sample_s1           (sample_s1),
		.off_ticks           (off_ticks_q),
		.before_sample_ticks (before_ticks_q),
		.after_sample_ticks  (after_ticks_q),
		.continuous_mode     (cont_q),
		.res_valid_s2        (res_valid_s2),
		.res_s2              (res_s2),
		.dividend_s2         (dividend_s2)
	);

	plss_mean #(
		.SAMPLES_PER_MEAN (SAMPLES_PER_MEAN)
	) u_mean (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid_s2 (res_valid_s2),
		.res_s2       (res_s2),
		.dividend_s2  (dividend_s2),
		.item_valid   (item_valid),
		.item         (item)
	);

	plss_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (OUT_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (item_valid),
		.wr_data   (item),
		.rd_en     (out_xfer),
		.rd_data   (fifo_out),
		.not_empty (m_axis_tvalid)
	);

	assign m_axis_tdata = {(24 - ITEM_W)'(0), fifo_out};

endmodule

FILE: tb/pulsed_led_sensor_sampler_unit_chk.sv
// Scoreboard for the pulsed LED sensor sampler: tracks registers, predicts each result, compares.
`timescale 1ns / 100ps

package plss_tb_pkg;

	// Register byte addresses on the APB port
	localparam logic [3:0] ADDR_OFF_TICKS    = 4'h0;
	localparam logic [3:0] ADDR_BEFORE_TICKS = 4'h4;
	localparam logic [3:0] ADDR_AFTER_TICKS  = 4'h8;
	localparam logic [3:0] ADDR_CONTINUOUS   = 4'hC;

	// Selector code with no function, ignored by the block
	localparam logic [1:0] FUNC_NONE = 2'd3;

endpackage

module pulsed_led_sensor_sampler_unit_chk import plss_pkg::*; import plss_tb_pkg::*; #(
	parameter int SAMPLES_PER_MEAN = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [9:0] sample_value, [15:10] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] func
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,   // [0] led_on, [1] start_conversion, [2] mean_valid,
	                                    // [15:3] mean_mv, [16] running, [23:17] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          errors,
	output int          outstanding,
	output int          results_checked,
	output int          means_checked
);

	// register shadow
	logic [15:0] off_len;
	logic [15:0] before_len;
	logic [15:0] after_len;
	logic        cont_run;

	// sequencer and accumulator shadow
	logic [1:0]        seq_phase;
	logic [15:0]       ticks_left;
	logic              led_level;
	logic              active;
	int unsigned       sample_count;
	int unsigned       sample_sum;
	logic [MEAN_W-1:0] held_mean;

	out_item_t expected_results[$];
	out_item_t got;
	out_item_t want;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v)
			report_mismatch($sformatf("result %0d %s expected %0d got %0d",
				results_checked, name, want_v, got_v));
	endtask

	// Advance the shadow sequencer by one item and return the result it should produce
	function automatic out_item_t sequencer_step(input logic [1:0] func, input logic [9:0] sample);
		out_item_t res;
		res = '0;
		case (func)
			FUNC_TICK: if (active) begin
				if (ticks_left > 16'd1) begin
					ticks_left = ticks_left - 16'd1;
				end else if (seq_phase == PH_BEFORE) begin
					res.start_conversion = 1'b1;
					seq_phase = PH_AFTER;
					ticks_left = after_len;
				end else if (seq_phase == PH_AFTER) begin
					led_level = 1'b0;
					seq_phase = PH_OFF;
					ticks_left = off_len;
				end else begin
					led_level = 1'b1;
					seq_phase = PH_BEFORE;
					ticks_left = before_len;
				end
			end
			FUNC_SAMPLE: if (active) begin
				sample_sum += sample;
				sample_count++;
				if (sample_count >= SAMPLES_PER_MEAN) begin
					held_mean = MEAN_W'((sample_sum * MV_PER_LSB) / SAMPLES_PER_MEAN);
					sample_sum = 0;
					sample_count = 0;
					res.mean_valid = 1'b1;
					// LED forced off on stop; continuous mode restarts in the off phase
					led_level = 1'b0;
					seq_phase = PH_OFF;
					active = cont_run;
					ticks_left = cont_run ? off_len : 16'd0;
				end
			end
			FUNC_TRIG: if (!active) begin
				active = 1'b1;
				led_level = 1'b0;
				seq_phase = PH_OFF;
				ticks_left = off_len;
			end
			default: ;
		endcase
		res.led_on = led_level;
		res.mean_mv = held_mean;
		res.running = active;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_len = 16'd9600;
			before_len = 16'd280;
			after_len = 16'd40;
			cont_run = 1'b1;
			seq_phase = PH_OFF;
			ticks_left = '0;
			led_level = 1'b0;
			active = 1'b0;
			sample_count = 0;
			sample_sum = 0;
			held_mean = '0;
			expected_results.delete();
			errors = 0;
			outstanding = 0;
			results_checked = 0;
			means_checked = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_OFF_TICKS:    off_len = pwdata[15:0];
					ADDR_BEFORE_TICKS: before_len = pwdata[15:0];
					ADDR_AFTER_TICKS:  after_len = pwdata[15:0];
					ADDR_CONTINUOUS:   cont_run = pwdata[0];
					default: ;
				endcase
			end
			// output side first: a result is registered in the pipeline and the queue before it
			// shows, so it never belongs to the input transfer of the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				got = out_item_t'(m_axis_tdata[16:0]);
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected, data %h",
						m_axis_tdata));
				end else begin
					want = expected_results.pop_front();
					check_field("led_on", want.led_on, got.led_on);
					check_field("start_conversion", want.start_conversion,
						got.start_conversion);
					check_field("mean_valid", want.mean_valid, got.mean_valid);
					check_field("mean_mv", want.mean_mv, got.mean_mv);
					check_field("running", want.running, got.running);
					if (want.mean_valid)
						means_checked++;
					results_checked++;
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(sequencer_step(s_axis_tuser, s_axis_tdata[9:0]));
			outstanding = expected_results.size();
		end
	end

endmodule

FILE: tb/pulsed_led_sensor_sampler_unit_tb.sv
// Top of the pulsed LED sensor sampler testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module pulsed_led_sensor_sampler_unit_tb;
	import plss_pkg::*;
	import plss_tb_pkg::*;

	localparam int SAMPLES_PER_MEAN = 16;
	localparam int CYCLE_LIMIT      = 400000;
	localparam int HOLD_CYCLES      = 60;      // long output stall, enough to fill the queue
	localparam int PHASES           = 12;
	localparam int PHASE_ITEMS      = 150;
	localparam int SETTLE_CYCLES    = 8;       // pipeline is four deep
	localparam int DRAIN_CYCLES     = 20;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [9:0] sample_value, [15:10] zero
	logic [1:0]  s_axis_tuser;   // [1:0] func
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // [0] led_on, [1] start_conversion, [2] mean_valid,
	                             // [15:3] mean_mv, [16] running, [23:17] zero
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// scoreboard status
	int errors;
	int outstanding;
	int results_checked;
	int means_checked;

	// stimulus bookkeeping
	int gap_max = 6;         // upper bound of idle cycles per transfer, both sides
	int hold_requests = 0;   // long output stalls asked for by the stimulus
	int holds_done = 0;      // long output stalls carried out
	int items_sent = 0;
	int settings_written = 0;
	int cycle_count = 0;

	pulsed_led_sensor_sampler_unit #(.SAMPLES_PER_MEAN(SAMPLES_PER_MEAN)) dut (.*);

	pulsed_led_sensor_sampler_unit_chk #(.SAMPLES_PER_MEAN(SAMPLES_PER_MEAN)) chk (.*);

	always #1 clk = ~clk;

	// APB write: setup phase, then access until pready is seen high
	task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
		logic rdy;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Load all four timing/mode registers; only called with the pipeline drained
	task automatic set_timing(input logic [15:0] off_t, input logic [15:0] before_t,
		input logic [15:0] after_t, input logic cont);
		apb_write(ADDR_OFF_TICKS, {16'd0, off_t});
		apb_write(ADDR_BEFORE_TICKS, {16'd0, before_t});
		apb_write(ADDR_AFTER_TICKS, {16'd0, after_t});
		apb_write(ADDR_CONTINUOUS, {31'd0, cont});
		settings_written++;
	endtask

	// One input transfer after a random gap. tvalid stays high across back-to-back
	// items so it is never dropped and raised in the same step. Ready is sampled on
	// the falling edge, where the registered outputs of the block are settled.
	task automatic send_item(input logic [1:0] func, input logic [9:0] sample);
		int gap;
		logic rdy;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= func;
		s_axis_tdata <= {6'd0, sample};
		do begin
			@(negedge clk);
			rdy = s_axis_tready;
			@(posedge clk);
		end while (!rdy);
		items_sent++;
	endtask

	// Stop offering, wait until every expected result has come out, then let the
	// pipeline run dry before touching the registers
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly short phase lengths so sequences cycle often; now and then zero
	// (treated as one tick) or full scale
	function automatic logic [15:0] pick_ticks();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 16'hFFFF;
		if (r == 1)
			return 16'd0;
		return 16'($urandom_range(1, 6));
	endfunction

	// Output side: random stall per result, plus a long hold-off on request while
	// the sender keeps pushing, so the result queue fills and input backs up
	initial begin
		int gap;
		logic vld;
		m_axis_tready <= 1'b0;
		@(posedge clk);
		forever begin
			gap = $urandom_range(0, gap_max);
			if (holds_done < hold_requests) begin
				holds_done++;
				m_axis_tready <= 1'b0;
				for (int i = 0; i < HOLD_CYCLES; i++)
					@(posedge clk);
			end else if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do begin
				@(negedge clk);
				vld = m_axis_tvalid;
				@(posedge clk);
			end while (!vld);
		end
	end

	// Watchdog: a hung handshake or a lost result ends the run here
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		int pick;
		logic [9:0] sample;

		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= FUNC_TICK;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: short phases, zero after-length, single-shot mode
		set_timing(16'd2, 16'd1, 16'd0, 1'b0);
		send_item(FUNC_TICK, 10'd0);        // tick while idle: no effect
		send_item(FUNC_SAMPLE, 10'd1023);   // sample while idle: not summed
		send_item(FUNC_NONE, 10'h3FF);      // unused selector
		send_item(FUNC_TRIG, 10'd0);        // first start after reset
		send_item(FUNC_TRIG, 10'd0);        // trigger while running: ignored
		// off 2 ticks, LED on, conversion pulse, after phase of zero acts as one
		repeat (4) send_item(FUNC_TICK, 10'h155);
		// full-scale samples give the largest mean, then single-shot stop
		repeat (SAMPLES_PER_MEAN) send_item(FUNC_SAMPLE, 10'd1023);
		send_item(FUNC_TICK, 10'h2AA);      // idle again
		send_item(FUNC_TRIG, 10'd0);        // restart by trigger

		// Random phases, each with its own register setting. Registers change
		// while the sequence may still be running; the new values take hold at
		// the next phase boundary.
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
				1: set_timing(16'd1, 16'd1, 16'd1, 1'b0);
				2: set_timing(16'd0, 16'd0, 16'd0, 1'b1);
				default: set_timing(pick_ticks(), pick_ticks(), pick_ticks(),
					1'($urandom_range(0, 1)));
			endcase
			// every fourth phase runs flat out on both sides
			gap_max = (p % 4 == 3) ? 0 : 6;
			if (p % 3 == 1)
				hold_requests++;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				sample = 10'($urandom_range(0, 1023));
				if (pick < 50) begin
					send_item(FUNC_TICK, sample);
				end else if (pick < 80) begin
					case ($urandom_range(0, 7))
						0: sample = 10'd0;
						1: sample = 10'd1023;
						default: ;
					endcase
					send_item(FUNC_SAMPLE, sample);
				end else if (pick < 95) begin
					send_item(FUNC_TRIG, sample);
				end else begin
					send_item(FUNC_NONE, sample);
				end
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items under %0d register settings; %0d results checked, %0d with a new mean.",
			items_sent, settings_written, results_checked, means_checked);
		$display("Included idle and unused-selector items, zero and full-scale phase lengths, %0d long output stalls.",
			holds_done);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
